@@ design/gbp_pkg.sv @@
// Shared types, constants and helper functions for the gshare branch predictor.
`timescale 1ns / 1ps

package gbp_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int HIST_BITS   = 10;
  localparam int HIST_W      = (HIST_BITS > 0) ? HIST_BITS : 1;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int CTR_W       = 2;
  localparam int COUNT_W     = 32;
  localparam int ADDR_W      = 32;
  localparam int QPTR_W      = 2;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;

  // Shifts that line the history up with the top of the index.
  localparam int HIST_SHL    = (HIST_BITS <= INDEX_BITS) ? (INDEX_BITS - HIST_BITS) : 0;
  localparam int HIST_SHR    = (HIST_BITS > INDEX_BITS) ? (HIST_BITS - INDEX_BITS) : 0;
  localparam int ALIGN_W     = INDEX_BITS + HIST_W;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [HIST_W-1:0]     hist_t;
  typedef logic [CTR_W-1:0]      ctr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [QPTR_W-1:0]     qptr_t;
  typedef logic [QPTR_W:0]       qcount_t;

  localparam ctr_t CTR_STRONG_NT = 2'd0;
  localparam ctr_t CTR_STRONG_T  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } branch_t;

  typedef struct packed {
    logic   predicted_taken;
    logic   mispredicted;
    count_t correct_total;
    count_t branch_total;
  } result_t;

  // One classified branch, as it travels from front to back.
  typedef struct packed {
    idx_t idx;
    logic taken;
  } work_t;

  // Back-end status seen by the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic idx_t align_hist(input hist_t hist);
    logic [ALIGN_W-1:0] w;
    w = ALIGN_W'(hist);
    if (HIST_BITS == 0) begin
      w = '0;
    end else if (HIST_BITS <= INDEX_BITS) begin
      w = w << HIST_SHL;
    end else begin
      w = w >> HIST_SHR;
    end
    return w[INDEX_BITS-1:0];
  endfunction

  function automatic hist_t hist_shift(input hist_t hist, input logic taken);
    hist_t h;
    h = (hist >> 1) | (HIST_W'(taken) << (HIST_W - 1));
    if (HIST_BITS == 0) begin
      h = '0;
    end
    return h;
  endfunction

  function automatic ctr_t ctr_update(input ctr_t ctr, input logic taken);
    ctr_t c;
    c = ctr;
    if (taken) begin
      if (ctr != CTR_STRONG_T) c = ctr + ctr_t'(1);
    end else begin
      if (ctr != CTR_STRONG_NT) c = ctr - ctr_t'(1);
    end
    return c;
  endfunction

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

endpackage

@@ design/gbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/gbp_front.sv @@
// Front end: accept branches, form the gshare index and advance the global history.
`timescale 1ns / 1ps

module gbp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 branch_valid,
  output logic                 branch_stall,
  input  gbp_pkg::branch_t     branch,
  input  gbp_pkg::back_status_t back_status,
  input  logic                 q_full,
  output logic                 push,
  output gbp_pkg::work_t       push_work
);

  gbp_pkg::hist_t history;
  gbp_pkg::idx_t  addr_idx;

  assign branch_stall = q_full || back_status.clearing;
  assign push         = branch_valid && !branch_stall;

  assign addr_idx       = branch.branch_address[gbp_pkg::INDEX_BITS+1:2];
  assign push_work.idx  = addr_idx ^ gbp_pkg::align_hist(history);
  assign push_work.taken = branch.taken;

  // History reflects every accepted branch in order, so it advances here.
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (push) begin
      history <= gbp_pkg::hist_shift(history, branch.taken);
    end
  end

endmodule

@@ design/gbp_queue.sv @@
// Short FIFO of classified branches between front and back ends.
`timescale 1ns / 1ps

module gbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gbp_pkg::work_t push_work,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output gbp_pkg::work_t head_work
);

  gbp_pkg::work_t   entries [gbp_pkg::QUEUE_DEPTH];
  gbp_pkg::qptr_t   wr_ptr;
  gbp_pkg::qptr_t   rd_ptr;
  gbp_pkg::qcount_t count;
  gbp_pkg::qcount_t count_next;

  assign full       = (count == gbp_pkg::qcount_t'(gbp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_work  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + gbp_pkg::qcount_t'(1);
    end else if (pop && !push) begin
      count_next = count - gbp_pkg::qcount_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_work;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + gbp_pkg::qptr_t'(1);
      if (pop)  rd_ptr <= rd_ptr + gbp_pkg::qptr_t'(1);
      count <= count_next;
    end
  end

endmodule

@@ design/gbp_back.sv @@
// Back end: counter table read-modify-write, running totals and result register.
`timescale 1ns / 1ps

module gbp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  gbp_pkg::work_t        head_work,
  output logic                  pop,
  output gbp_pkg::back_status_t back_status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output gbp_pkg::result_t      result
);

  // Clearing sweep
  logic           clearing;
  gbp_pkg::idx_t  clear_addr;

  // Read stage: entry whose table read is in flight
  logic           s1_valid;
  gbp_pkg::work_t s1_work;
  logic           s1_hit;
  gbp_pkg::ctr_t  s1_fwd;
  logic           s1_fire;

  gbp_pkg::ctr_t  rd_ctr;
  gbp_pkg::ctr_t  cur_ctr;
  gbp_pkg::ctr_t  new_ctr;
  logic           pred;
  logic           miss;

  logic            we;
  gbp_pkg::idx_t   waddr;
  gbp_pkg::ctr_t   wdata;

  gbp_pkg::count_t correct_count;
  gbp_pkg::count_t total_count;
  gbp_pkg::count_t correct_count_next;
  gbp_pkg::count_t total_count_next;

  assign back_status.clearing = clearing;

  assign s1_fire = s1_valid && (!result_valid || !result_stall);
  assign pop     = head_valid && !clearing && (!s1_valid || s1_fire);

  // Forward the counter written in the cycle this entry's read was issued.
  assign cur_ctr = s1_hit ? s1_fwd : rd_ctr;
  assign pred    = cur_ctr[1];
  assign miss    = (pred != s1_work.taken);
  assign new_ctr = gbp_pkg::ctr_update(cur_ctr, s1_work.taken);

  assign correct_count_next = miss ? correct_count : gbp_pkg::sat_inc(correct_count);
  assign total_count_next   = gbp_pkg::sat_inc(total_count);

  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clear_addr;
      wdata = gbp_pkg::CTR_STRONG_NT;
    end else begin
      we    = s1_fire;
      waddr = s1_work.idx;
      wdata = new_ctr;
    end
  end

  gbp_ram #(
    .WIDTH (gbp_pkg::CTR_W),
    .DEPTH (gbp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (pop),
    .raddr (head_work.idx),
    .rdata (rd_ctr)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_work <= head_work;
      s1_hit  <= s1_fire && (s1_work.idx == head_work.idx);
      s1_fwd  <= new_ctr;
    end
    if (s1_fire) begin
      result.predicted_taken <= pred;
      result.mispredicted    <= miss;
      result.correct_total   <= correct_count_next;
      result.branch_total    <= total_count_next;
    end
    if (rst) begin
      clearing      <= 1'b1;
      clear_addr    <= '0;
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
      correct_count <= '0;
      total_count   <= '0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + gbp_pkg::idx_t'(1);
        if (clear_addr == '1) clearing <= 1'b0;
      end
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        result_valid  <= 1'b1;
        correct_count <= correct_count_next;
        total_count   <= total_count_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/gshare_branch_predictor.sv @@
// Top level of the gshare branch predictor with 2-bit saturating counters.
`timescale 1ns / 1ps

// Each input beat is one resolved branch (address and outcome); each output
// beat carries the prediction the table held for it before the update, a
// mispredict flag, and saturating running totals of correct predictions and
// of branches. The table index is address bits [INDEX_BITS+1:2] XORed with
// the global history lined up with the top of the index. After reset the
// block sweeps the 4096-entry counter table to strongly-not-taken, one entry
// per cycle, and holds branch_stall high until the sweep ends. After that it
// takes one branch per cycle while the queue is not full. The front end forms
// the index and advances the history as each beat is accepted and pushes it
// into a four-entry queue; the back end issues the table read, then, once the
// read data is registered and the output is not stalled, updates the counter
// (with a bypass for a back-to-back branch to the same entry), the totals and
// the output register. The single table write port sets the one-per-cycle rate.
module gshare_branch_predictor (
  input  logic              clk,
  input  logic              rst,
  input  logic              branch_valid,
  output logic              branch_stall,
  input  gbp_pkg::branch_t  branch,
  output logic              result_valid,
  input  logic              result_stall,
  output gbp_pkg::result_t  result
);

  gbp_pkg::back_status_t back_status;
  logic                  q_full;
  logic                  push;
  gbp_pkg::work_t        push_work;
  logic                  pop;
  logic                  head_valid;
  gbp_pkg::work_t        head_work;

  // Classify: index and history, in acceptance order.
  gbp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .branch_valid (branch_valid),
    .branch_stall (branch_stall),
    .branch       (branch),
    .back_status  (back_status),
    .q_full       (q_full),
    .push         (push),
    .push_work    (push_work)
  );

  // Decouple the two sides so an output stall does not reach the input at once.
  gbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_work  (push_work),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_work  (head_work)
  );

  // Predict and update the counter table, totals and result register.
  gbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_work    (head_work),
    .pop          (pop),
    .back_status  (back_status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the gshare branch predictor with 2-bit counters.
`timescale 1ns / 1ps

// Branch beats are driven with random gaps and result beats are taken under
// random stall. Every accepted branch runs through a local gshare model:
// index = address[INDEX_BITS+1:2] XOR history aligned to the top of the index,
// 2-bit counter lookup and update, history shift, saturating totals. The model
// output is queued and compared field by field against the next result beat.
// A short directed table comes first. A biased random stream follows, with
// hot branches so that counters climb to taken and saturate. A quiet window
// with no idling on either side runs partway through. One full drain pause
// comes later.
module tb_top;

  localparam int N_RANDOM     = 1000;
  localparam int STUCK_LIMIT  = 20000;   // covers the table sweep after reset
  localparam int QUIET_FIRST  = 300;
  localparam int QUIET_LAST   = 499;
  localparam int DRAIN_AT     = 650;
  localparam int N_HOT        = 8;
  localparam int N_DIRECTED   = 22;
  localparam logic [31:0] IDX_MASK  = (32'd1 << gbp_pkg::INDEX_BITS) - 32'd1;
  localparam logic [31:0] HIST_MASK = 32'((64'd1 << gbp_pkg::HIST_BITS) - 64'd1);

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             branch_valid = 1'b0;
  logic             branch_stall;
  gbp_pkg::branch_t branch = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  gbp_pkg::result_t result;

  gshare_branch_predictor uut (
    .clk          (clk),
    .rst          (rst),
    .branch_valid (branch_valid),
    .branch_stall (branch_stall),
    .branch       (branch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local gshare state, the mirror of the block's table, history and totals.
  logic [gbp_pkg::CTR_W-1:0] pht [gbp_pkg::TABLE_DEPTH];
  logic [31:0]               ghist;
  gbp_pkg::count_t           n_correct;
  gbp_pkg::count_t           n_branches;

  gbp_pkg::result_t pending_results [$];
  int               n_errors = 0;
  bit               quiet = 1'b0;   // no idling on either side while set

  // One directed beat. Rows with check_fixed carry an expected result that
  // follows directly from the reset state; the rest rely on the model.
  typedef struct packed {
    logic [31:0] addr;
    logic        tkn;
    logic        check_fixed;
    logic        pred;
    logic        miss;
    logic [31:0] corr;
    logic [31:0] tot;
  } branch_row_t;

  branch_row_t directed_rows [N_DIRECTED] = '{
    // cold table, counter 0 and outcome not taken: correct, already at floor
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 32'd1, 32'd1},
    // all address bits set, cold entry 0xFFF, taken: a miss
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 32'd1, 32'd2},
    // low two bits and bits above the index must be ignored
    '{32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'hFFFF_C000, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h5555_5554, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'hAAAA_AAA8, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    // one hot branch, always taken: history fills with ones, then the entry
    // climbs to strongly taken and saturates there
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    // strongly taken entry meets a not-taken outcome: predicted taken, a miss
    '{32'h0000_1000, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}
  };

  // Advance the local gshare state by one resolved branch and return the
  // result beat that the block must produce for it.
  task automatic predict_branch(input gbp_pkg::branch_t b, output gbp_pkg::result_t r);
    logic [31:0]               hist_al;
    gbp_pkg::idx_t             idx;
    logic [gbp_pkg::CTR_W-1:0] ctr;
    logic                      pred;
    if (gbp_pkg::HIST_BITS == 0) begin
      hist_al = '0;
    end else if (gbp_pkg::HIST_BITS <= gbp_pkg::INDEX_BITS) begin
      hist_al = (ghist & HIST_MASK) << (gbp_pkg::INDEX_BITS - gbp_pkg::HIST_BITS);
    end else begin
      hist_al = (ghist & HIST_MASK) >> (gbp_pkg::HIST_BITS - gbp_pkg::INDEX_BITS);
    end
    idx  = gbp_pkg::idx_t'(((b.branch_address >> 2) ^ hist_al) & IDX_MASK);
    ctr  = pht[idx];
    pred = ctr[1];
    // move one step toward the outcome, hold at either end
    if (b.taken && ctr != gbp_pkg::CTR_STRONG_T) begin
      ctr = ctr + 2'd1;
    end else if (!b.taken && ctr != gbp_pkg::CTR_STRONG_NT) begin
      ctr = ctr - 2'd1;
    end
    pht[idx] = ctr;
    if (pred == b.taken && n_correct != '1) begin
      n_correct = n_correct + 1;
    end
    if (n_branches != '1) begin
      n_branches = n_branches + 1;
    end
    // shift history right, outcome enters at the top
    if (gbp_pkg::HIST_BITS > 0) begin
      ghist = ((ghist >> 1) | (32'(b.taken) << (gbp_pkg::HIST_BITS - 1))) & HIST_MASK;
    end
    r.predicted_taken = pred;
    r.mispredicted    = pred ^ b.taken;
    r.correct_total   = n_correct;
    r.branch_total    = n_branches;
  endtask

  // Drive one branch beat, with random gaps outside the quiet window. Hold
  // the payload until the block takes it, then queue the expected result.
  task automatic send_branch(input gbp_pkg::branch_t b, input bit check_fixed,
                             input gbp_pkg::result_t fixed_res);
    gbp_pkg::result_t model_res;
    while (!quiet && $urandom_range(99) < 15) begin
      branch_valid <= 1'b0;
      @(posedge clk);
    end
    branch_valid <= 1'b1;
    branch       <= b;
    do @(posedge clk); while (branch_stall);
    predict_branch(b, model_res);
    if (check_fixed) begin
      model_res = fixed_res;
    end
    pending_results = {pending_results, model_res};
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
      n_errors++;
    end
  endfunction

  // Stimulus: reset, directed table, then the biased random stream.
  initial begin
    gbp_pkg::branch_t b;
    gbp_pkg::result_t fixed_res;
    logic [31:0]      hot_addr [N_HOT];
    int               hot_bias [N_HOT];
    int               j;
    for (int i = 0; i < gbp_pkg::TABLE_DEPTH; i++) begin
      pht[i] = '0;
    end
    ghist      = '0;
    n_correct  = '0;
    n_branches = '0;
    // hot branches: mostly taken, mostly not taken, or a coin flip
    for (int i = 0; i < N_HOT; i++) begin
      hot_addr[i] = $urandom;
      hot_bias[i] = (i % 3 == 0) ? 92 : (i % 3 == 1) ? 8 : 50;
    end

    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      b.branch_address          = directed_rows[i].addr;
      b.taken                   = directed_rows[i].tkn;
      fixed_res.predicted_taken = directed_rows[i].pred;
      fixed_res.mispredicted    = directed_rows[i].miss;
      fixed_res.correct_total   = directed_rows[i].corr;
      fixed_res.branch_total    = directed_rows[i].tot;
      send_branch(b, directed_rows[i].check_fixed, fixed_res);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      quiet = (k >= QUIET_FIRST && k <= QUIET_LAST);
      // drop valid and let the pipe drain completely once
      if (k == DRAIN_AT) begin
        branch_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if ($urandom_range(99) < 75) begin
        j                = $urandom_range(N_HOT - 1);
        b.branch_address = hot_addr[j];
        b.taken          = ($urandom_range(99) < hot_bias[j]);
      end else begin
        b.branch_address = $urandom;
        b.taken          = 1'($urandom_range(1));
      end
      send_branch(b, 1'b0, '0);
    end
    quiet = 1'b0;

    branch_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: check each accepted beat against the oldest expectation,
  // pick the next stall, and watch for a hang.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    gbp_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no branch outstanding");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("predicted_taken", 32'(want.predicted_taken), 32'(result.predicted_taken));
        check_field("mispredicted", 32'(want.mispredicted), 32'(result.mispredicted));
        check_field("correct_total", want.correct_total, result.correct_total);
        check_field("branch_total", want.branch_total, result.branch_total);
      end
    end
    result_stall <= !quiet && ($urandom_range(99) < 15);

    if ((branch_valid && !branch_stall) || (result_valid && !result_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
